// File: sv/lfmc_pkg.sv
// Shared types, codes and maneuver tables for the line follower maneuver control core.
// No dependencies; every other file in this block imports it.
`default_nettype none

package lfmc_pkg;

    localparam int SensorWidth = 5;
    localparam int DriveWidth  = 2;
    localparam int TickWidth   = 5;

    typedef logic [SensorWidth-1:0] sensors_t;
    typedef logic [DriveWidth-1:0]  drive_t;
    typedef logic [TickWidth-1:0]   ticks_t;

    typedef enum logic [1:0] {
        COL_UNKNOWN = 2'd0,
        COL_WHITE   = 2'd1,
        COL_BLACK   = 2'd2
    } colour_t;

    typedef enum logic [1:0] {
        HD_NONE     = 2'd0,
        HD_RIGHT    = 2'd1,
        HD_LEFT     = 2'd2,
        HD_STRAIGHT = 2'd3
    } heading_t;

    typedef enum logic [3:0] {
        MV_IDLE        = 4'd0,
        MV_LEFT        = 4'd1,
        MV_SMALL_LEFT  = 4'd2,
        MV_RIGHT       = 4'd3,
        MV_SMALL_RIGHT = 4'd4,
        MV_MINI_LEFT   = 4'd5,
        MV_MINI_RIGHT  = 4'd6,
        MV_STRAIGHT    = 4'd7,
        MV_FAST        = 4'd8
    } maneuver_t;

    localparam drive_t DRIVE_OFF   = 2'b00;
    localparam drive_t DRIVE_LEFT  = 2'b01;
    localparam drive_t DRIVE_RIGHT = 2'b10;
    localparam drive_t DRIVE_BOTH  = 2'b11;

    typedef struct packed {
        sensors_t line_sensors;
        logic     start_switch;
    } in_item_t;

    typedef struct packed {
        drive_t   motor_drive;
        sensors_t led_mirror;
        logic     maneuver_active;
    } out_item_t;

    // Decision of the pattern table for one sampled pattern.
    typedef struct packed {
        maneuver_t maneuver;
        logic      update;
        colour_t   colour;
        heading_t  heading;
    } choice_t;

    function automatic drive_t mv_drive(input maneuver_t mv);
        drive_t d;
        d = DRIVE_OFF;
        case (mv)
            MV_LEFT, MV_SMALL_LEFT, MV_MINI_LEFT:    d = DRIVE_RIGHT;
            MV_RIGHT, MV_SMALL_RIGHT, MV_MINI_RIGHT: d = DRIVE_LEFT;
            MV_STRAIGHT, MV_FAST:                    d = DRIVE_BOTH;
            default:                                 d = DRIVE_OFF;
        endcase
        return d;
    endfunction

    function automatic ticks_t mv_on(input maneuver_t mv);
        ticks_t t;
        t = '0;
        case (mv)
            MV_LEFT, MV_RIGHT:             t = ticks_t'(15);
            MV_SMALL_LEFT, MV_SMALL_RIGHT: t = ticks_t'(8);
            MV_MINI_LEFT, MV_MINI_RIGHT:   t = ticks_t'(4);
            MV_STRAIGHT:                   t = ticks_t'(10);
            MV_FAST:                       t = ticks_t'(20);
            default:                       t = '0;
        endcase
        return t;
    endfunction

    function automatic ticks_t mv_off(input maneuver_t mv);
        ticks_t t;
        t = '0;
        case (mv)
            MV_LEFT, MV_RIGHT:             t = ticks_t'(20);
            MV_SMALL_LEFT, MV_SMALL_RIGHT: t = ticks_t'(16);
            MV_MINI_LEFT, MV_MINI_RIGHT:   t = ticks_t'(8);
            MV_STRAIGHT:                   t = ticks_t'(10);
            MV_FAST:                       t = ticks_t'(5);
            default:                       t = '0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// File: sv/lfmc_choose.sv
// Pattern table: picks a maneuver for a sampled sensor pattern.
// Depends on lfmc_pkg for the colour, heading and maneuver codes.
`default_nettype none

module lfmc_choose
    import lfmc_pkg::*;
(
    input  wire sensors_t pattern,
    input  wire colour_t  colour,
    input  wire heading_t heading,
    output choice_t       choice
);

    logic white;
    logic black;

    assign white = (colour == COL_WHITE);
    assign black = (colour == COL_BLACK);

    always_comb begin
        choice.maneuver = MV_STRAIGHT;
        choice.update   = 1'b0;
        choice.colour   = colour;
        choice.heading  = heading;
        unique case (pattern) inside
            // white surface patterns
            5'd15: choice = '{MV_RIGHT, 1'b1, COL_WHITE, HD_RIGHT};
            5'd7: begin
                if (black) choice.maneuver = MV_SMALL_LEFT;
                else       choice = '{MV_SMALL_RIGHT, 1'b1, COL_WHITE, HD_RIGHT};
            end
            5'd27: choice = '{MV_FAST, 1'b1, COL_WHITE, HD_STRAIGHT};
            5'd28: begin
                if (black) choice.maneuver = MV_SMALL_RIGHT;
                else       choice = '{MV_SMALL_LEFT, 1'b1, COL_WHITE, HD_LEFT};
            end
            5'd30: choice = '{MV_LEFT, 1'b1, COL_WHITE, HD_LEFT};
            5'd25, 5'd29: choice = '{MV_MINI_LEFT, 1'b1, COL_WHITE, HD_LEFT};
            5'd19, 5'd23: choice = '{MV_MINI_RIGHT, 1'b1, COL_WHITE, HD_RIGHT};
            // black surface patterns
            5'd16: choice = '{MV_RIGHT, 1'b1, COL_BLACK, HD_RIGHT};
            5'd24: begin
                if (white) choice.maneuver = MV_SMALL_LEFT;
                else       choice = '{MV_SMALL_RIGHT, 1'b1, COL_BLACK, HD_RIGHT};
            end
            5'd4: choice = '{MV_FAST, 1'b1, COL_BLACK, HD_STRAIGHT};
            5'd3: begin
                if (white) choice.maneuver = MV_SMALL_RIGHT;
                else       choice = '{MV_SMALL_LEFT, 1'b1, COL_BLACK, HD_LEFT};
            end
            5'd1: choice = '{MV_LEFT, 1'b1, COL_BLACK, HD_LEFT};
            5'd12: choice = '{MV_MINI_RIGHT, 1'b1, COL_BLACK, HD_RIGHT};
            5'd6: choice = '{MV_MINI_LEFT, 1'b1, COL_BLACK, HD_LEFT};
            // crossed heading: the turn goes one way, the heading records the other
            5'd8: choice = '{MV_MINI_RIGHT, 1'b1, COL_BLACK, HD_LEFT};
            5'd2: choice = '{MV_MINI_LEFT, 1'b1, COL_BLACK, HD_RIGHT};
            // off the line: repeat the last heading
            5'd0, 5'd31: begin
                case (heading)
                    HD_RIGHT:    choice.maneuver = MV_RIGHT;
                    HD_LEFT:     choice.maneuver = MV_LEFT;
                    HD_STRAIGHT: choice.maneuver = MV_STRAIGHT;
                    default:     choice.maneuver = MV_IDLE;
                endcase
            end
            default: choice.maneuver = MV_STRAIGHT;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/line_follower_maneuver_control_core.sv
// Line follower maneuver control: top level with the tick state and the result register.
// Depends on lfmc_pkg and lfmc_choose.
//
// Usage:
//   Each input item on the s_ channel is one timing tick carrying the five line
//   sensors and the start switch level (0 = pressed). Each accepted item yields
//   exactly one result item on the m_ channel: motor drive, LED mirror of the
//   sensors latched at the last sampling, and a flag set while a maneuver phase
//   is counting.
//   The result of an accepted item is registered and presented on m_ in the
//   cycle after it is accepted. Throughput is one item per cycle while m_ready
//   stays high, set by the single result register: s_ready is high whenever
//   that register is empty or being taken in the same cycle.
//   When the receiver stalls, the result register holds its item and s_ready
//   drops, so no further tick is taken until the result is taken.
//   Reset (aresetn low, synchronous) clears the run flag, colour, heading,
//   maneuver, phase, tick counter and LED latch, and empties the result
//   register. The motors stay off until the start switch first reads 0.
`default_nettype none

module line_follower_maneuver_control_core
    import lfmc_pkg::*;
(
    input  wire       aclk,
    input  wire       aresetn,

    input  wire       s_valid,
    output logic      s_ready,
    input  wire in_item_t s_item,

    output logic      m_valid,
    input  wire       m_ready,
    output out_item_t m_result
);

    // tick state
    logic      run_reg,      run_next;
    colour_t   colour_reg,   colour_next;
    heading_t  heading_reg,  heading_next;
    maneuver_t mv_reg,       mv_next;
    logic      phase_reg,    phase_next;
    ticks_t    ticks_reg,    ticks_next;
    sensors_t  latch_reg,    latch_next;

    // result register
    logic      m_valid_reg;
    out_item_t result_reg,   result_next;

    logic      accept;
    maneuver_t mv_cur;
    choice_t   choice;

    // advance the result register when empty or when its item is taken
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

    // treat any code beyond the table as idle
    assign mv_cur = (mv_reg > MV_FAST) ? MV_IDLE : mv_reg;

    lfmc_choose u_choose (
        .pattern (s_item.line_sensors),
        .colour  (colour_reg),
        .heading (heading_reg),
        .choice  (choice)
    );

    always_comb begin
        maneuver_t mv_w;
        logic      phase_w;
        ticks_t    ticks_w;

        run_next     = run_reg;
        colour_next  = colour_reg;
        heading_next = heading_reg;
        latch_next   = latch_reg;
        mv_w         = mv_cur;
        phase_w      = phase_reg;
        ticks_w      = ticks_reg;

        result_next.motor_drive     = DRIVE_OFF;
        result_next.maneuver_active = 1'b0;

        // before the run: mirror sensors, wait for the switch
        if (!run_reg) begin
            latch_next = s_item.line_sensors;
            if (!s_item.start_switch) run_next = 1'b1;
        end

        if (run_next) begin
            // sample and pick a maneuver when none is running
            if (mv_w == MV_IDLE) begin
                latch_next = s_item.line_sensors;
                mv_w       = choice.maneuver;
                phase_w    = 1'b0;
                ticks_w    = mv_on(choice.maneuver);
                if (choice.update) begin
                    colour_next  = choice.colour;
                    heading_next = choice.heading;
                end
            end
            // run one tick of the current phase
            if (mv_w != MV_IDLE) begin
                result_next.maneuver_active = 1'b1;
                result_next.motor_drive     = phase_w ? DRIVE_OFF : mv_drive(mv_w);
                if (ticks_w != '0) ticks_w = ticks_w - ticks_t'(1);
                if (ticks_w == '0) begin
                    if (!phase_w) begin
                        phase_w = 1'b1;
                        ticks_w = mv_off(mv_w);
                    end
                    if (ticks_w == '0) begin
                        mv_w    = MV_IDLE;
                        phase_w = 1'b0;
                    end
                end
            end
        end

        mv_next                = mv_w;
        phase_next             = phase_w;
        ticks_next             = ticks_w;
        result_next.led_mirror = latch_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= 1'b0;
            colour_reg  <= COL_UNKNOWN;
            heading_reg <= HD_NONE;
            mv_reg      <= MV_IDLE;
            phase_reg   <= 1'b0;
            ticks_reg   <= '0;
            latch_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                run_reg     <= run_next;
                colour_reg  <= colour_next;
                heading_reg <= heading_next;
                mv_reg      <= mv_next;
                phase_reg   <= phase_next;
                ticks_reg   <= ticks_next;
                latch_reg   <= latch_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (accept) result_reg <= result_next;
    end

endmodule

`default_nettype wire
